// ===== rtl/core/rsi_pkg.sv =====
// Shared types, widths and register codes of the ray and segment intersection core.
package rsi_pkg;

  localparam int COORD_WIDTH          = 24;
  localparam int COORD_FRAC_BITS_DEF  = 8;
  localparam int TOL_WIDTH            = 16;
  localparam int CFG_INDEX_WIDTH      = 4;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_POSITION_TOL  = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION_TOL = CFG_INDEX_WIDTH'(1);

  // Difference of two coordinates, cross products and the scaled numerator.
  localparam int DIFF_WIDTH    = COORD_WIDTH + 1;
  localparam int CROSS_WIDTH   = 2 * DIFF_WIDTH + 1;
  localparam int SPLIT_LO      = (CROSS_WIDTH + 1) / 2;
  localparam int SPLIT_HI      = CROSS_WIDTH - SPLIT_LO;
  localparam int PP_LO_WIDTH   = DIFF_WIDTH + SPLIT_LO + 1;
  localparam int PP_HI_WIDTH   = DIFF_WIDTH + SPLIT_HI;
  localparam int NUMER_WIDTH   = DIFF_WIDTH + CROSS_WIDTH;
  localparam int MAG_WIDTH     = NUMER_WIDTH + 2;
  localparam int QUOT_WIDTH    = COORD_WIDTH + 1;
  localparam int DIVISOR_WIDTH = CROSS_WIDTH + 1;
  localparam int TOP_WIDTH     = MAG_WIDTH - QUOT_WIDTH;

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ray_origin_x;
    logic signed [COORD_WIDTH-1:0] ray_origin_y;
    logic signed [COORD_WIDTH-1:0] ray_target_x;
    logic signed [COORD_WIDTH-1:0] ray_target_y;
    logic signed [COORD_WIDTH-1:0] seg_start_x;
    logic signed [COORD_WIDTH-1:0] seg_start_y;
    logic signed [COORD_WIDTH-1:0] seg_end_x;
    logic signed [COORD_WIDTH-1:0] seg_end_y;
  } item_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
  } result_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [DIFF_WIDTH-1:0]  rx;
    logic signed [DIFF_WIDTH-1:0]  ry;
    logic signed [DIFF_WIDTH-1:0]  sx;
    logic signed [DIFF_WIDTH-1:0]  sy;
    logic                          sel_x;
    logic                          seg_zero;
  } ctx_t;

  typedef struct packed {
    ctx_t                          ctx;
    logic signed [CROSS_WIDTH-1:0] den;
    logic signed [CROSS_WIDTH-1:0] num;
  } qent_t;

endpackage

// ===== rtl/core/ray_segment_intersection_core.sv =====
// Top level of the ray and segment intersection core: config registers, front, queue and back.
//
// Each input word carries a ray (origin and a point it passes through) and a segment, all as
// signed fixed-point coordinates. Each word yields exactly one result word: the crossing point
// of the two supporting lines, rounded and saturated to the coordinate range (zero when the
// lines are parallel), and a hit flag for a crossing inside the segment and ahead of the ray.
// Both data channels use valid and stall; a word moves at a rising edge with valid high and
// stall low. Input stall is driven from registers only.
// A new word is accepted every cycle while item_stall is low. The divider resolves one quotient
// bit per pipeline stage for each of the two coordinates.
// When the receiver stalls, the back pipeline holds in place while the front keeps accepting
// words until the four-entry queue is full and a word waits in the last of the three front
// stages; then item_stall rises.
// The config channel is always ready. Write register 0 for the position tolerance and
// register 1 for the direction tolerance, only while no word is in flight; other indexes are
// ignored. Synchronous reset empties the pipelines and the queue and clears both tolerances.
module ray_segment_intersection_core
  import rsi_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  item_t                      item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output result_t                    result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [TOL_WIDTH-1:0]       cfg_data
);

  logic [TOL_WIDTH-1:0] position_tolerance;
  logic [TOL_WIDTH-1:0] direction_tolerance;

  logic  push, q_full, q_avail, q_pop;
  qent_t push_data, q_head;

  // Config writes take effect at once; the block never needs to hold them off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_tolerance  <= '0;
      direction_tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POSITION_TOL:  position_tolerance  <= cfg_data;
        REG_DIRECTION_TOL: direction_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // The front computes differences, cross products and the segment axis choice.
  rsi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  // The queue lets the front keep accepting words while the output is stalled.
  rsi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_head)
  );

  // The back divides, saturates the point and runs the position and direction tests.
  rsi_back #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .avail        (q_avail),
    .head         (q_head),
    .pop          (q_pop),
    .pos_tol      (position_tolerance),
    .dir_tol      (direction_tolerance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/core/rsi_front.sv =====
// Front end: accepts words, forms differences, cross products and the segment axis choice.
module rsi_front
  import rsi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item,
  input  logic  q_full,
  output logic  push,
  output qent_t push_data
);

  logic [2:0] vld;
  logic       adv;

  logic signed [COORD_WIDTH-1:0]  ax1, ay1, cx1, cy1;
  logic signed [DIFF_WIDTH-1:0]   rx1, ry1, sx1, sy1, ex1, ey1;

  logic signed [2*DIFF_WIDTH-1:0] p_rs2, p_rys2, p_es2, p_eys2;
  ctx_t                           ctx2;
  logic [DIFF_WIDTH-1:0]          sx_abs, sy_abs;
  logic                           sel_x;

  ctx_t                           ctx3;
  logic signed [CROSS_WIDTH-1:0]  den3, num3;

  // The whole front advances together; it holds only when its last word cannot enter the queue.
  assign adv        = !(vld[2] && q_full);
  assign item_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax1 <= item.ray_origin_x;
      ay1 <= item.ray_origin_y;
      cx1 <= item.seg_start_x;
      cy1 <= item.seg_start_y;
      rx1 <= DIFF_WIDTH'(item.ray_target_x) - DIFF_WIDTH'(item.ray_origin_x);
      ry1 <= DIFF_WIDTH'(item.ray_target_y) - DIFF_WIDTH'(item.ray_origin_y);
      sx1 <= DIFF_WIDTH'(item.seg_end_x) - DIFF_WIDTH'(item.seg_start_x);
      sy1 <= DIFF_WIDTH'(item.seg_end_y) - DIFF_WIDTH'(item.seg_start_y);
      ex1 <= DIFF_WIDTH'(item.seg_start_x) - DIFF_WIDTH'(item.ray_origin_x);
      ey1 <= DIFF_WIDTH'(item.seg_start_y) - DIFF_WIDTH'(item.ray_origin_y);
    end
  end

  // Position is measured on the longer segment axis, y on a tie.
  assign sx_abs = sx1[DIFF_WIDTH-1] ? -sx1 : sx1;
  assign sy_abs = sy1[DIFF_WIDTH-1] ? -sy1 : sy1;
  assign sel_x  = sx_abs > sy_abs;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rs2         <= rx1 * sy1;
      p_rys2        <= ry1 * sx1;
      p_es2         <= ex1 * sy1;
      p_eys2        <= ey1 * sx1;
      ctx2.ax       <= ax1;
      ctx2.ay       <= ay1;
      ctx2.cx       <= cx1;
      ctx2.cy       <= cy1;
      ctx2.rx       <= rx1;
      ctx2.ry       <= ry1;
      ctx2.sx       <= sx1;
      ctx2.sy       <= sy1;
      ctx2.sel_x    <= sel_x;
      ctx2.seg_zero <= !sel_x && (sy_abs == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx3 <= ctx2;
      den3 <= CROSS_WIDTH'(p_rs2) - CROSS_WIDTH'(p_rys2);
      num3 <= CROSS_WIDTH'(p_es2) - CROSS_WIDTH'(p_eys2);
    end
  end

  assign push          = vld[2] && adv;
  assign push_data.ctx = ctx3;
  assign push_data.den = den3;
  assign push_data.num = num3;

endmodule

// ===== rtl/core/rsi_queue.sv =====
// Short queue that decouples the front end from the back end.
module rsi_queue
  import rsi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  avail,
  output qent_t pop_data
);

  qent_t                   mem [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_WIDTH-1:0] count;

  assign full     = count == QCOUNT_WIDTH'(QUEUE_DEPTH);
  assign avail    = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !avail))
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == QCOUNT_WIDTH'($past(count) + 1'b1))
    else $error("queue count did not follow a write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == QCOUNT_WIDTH'($past(count) - 1'b1))
    else $error("queue count did not follow a read");
`endif

endmodule

// ===== rtl/core/rsi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detection.
module rsi_divider
  import rsi_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [MAG_WIDTH-1:0]     mag,
  input  logic [DIVISOR_WIDTH-1:0] dd,
  input  logic                     neg,
  output logic [QUOT_WIDTH-1:0]    quot,
  output logic                     ovf,
  output logic                     neg_out
);

  logic [DIVISOR_WIDTH-1:0] rem  [QUOT_WIDTH+1];
  logic [DIVISOR_WIDTH-1:0] dsr  [QUOT_WIDTH+1];
  logic [QUOT_WIDTH-1:0]    low  [QUOT_WIDTH+1];
  logic [QUOT_WIDTH-1:0]    q    [QUOT_WIDTH+1];
  logic                     ovfr [QUOT_WIDTH+1];
  logic                     negr [QUOT_WIDTH+1];
  logic [TOP_WIDTH-1:0]     top;
  logic [TOP_WIDTH-1:0]     dd_top;

  // A quotient that needs more bits than kept is flagged and later saturated.
  assign top    = mag[MAG_WIDTH-1:QUOT_WIDTH];
  assign dd_top = {{(TOP_WIDTH-DIVISOR_WIDTH){1'b0}}, dd};

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= top[DIVISOR_WIDTH-1:0];
      dsr[0]  <= dd;
      low[0]  <= mag[QUOT_WIDTH-1:0];
      q[0]    <= '0;
      ovfr[0] <= top >= dd_top;
      negr[0] <= neg;
    end
  end

  for (genvar i = 1; i <= QUOT_WIDTH; i++) begin : g_stage
    logic [DIVISOR_WIDTH:0] trial;
    logic                   ge;

    assign trial = {rem[i-1], low[i-1][QUOT_WIDTH-1]};
    assign ge    = trial >= {1'b0, dsr[i-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? DIVISOR_WIDTH'(trial - {1'b0, dsr[i-1]}) : trial[DIVISOR_WIDTH-1:0];
        dsr[i]  <= dsr[i-1];
        low[i]  <= {low[i-1][QUOT_WIDTH-2:0], 1'b0};
        q[i]    <= {q[i-1][QUOT_WIDTH-2:0], ge};
        ovfr[i] <= ovfr[i-1];
        negr[i] <= negr[i-1];
      end
    end
  end

  assign quot    = q[QUOT_WIDTH];
  assign ovf     = ovfr[QUOT_WIDTH];
  assign neg_out = negr[QUOT_WIDTH];

endmodule

// ===== rtl/core/rsi_back.sv =====
// Back end: intersection point by division, saturation, position and direction tests.
module rsi_back
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = COORD_FRAC_BITS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 avail,
  input  qent_t                head,
  output logic                 pop,
  input  logic [TOL_WIDTH-1:0] pos_tol,
  input  logic [TOL_WIDTH-1:0] dir_tol,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result
);

  localparam int DIV_LAT   = QUOT_WIDTH + 1;
  localparam int NSTAGE    = DIV_LAT + 8;
  localparam int SUM_WIDTH = COORD_WIDTH + 3;
  localparam int PT_WIDTH  = DIFF_WIDTH + TOL_WIDTH + 3;
  localparam int DOT_WIDTH = 2 * DIFF_WIDTH + 1;
  localparam int DT_WIDTH  = DOT_WIDTH + TOL_WIDTH + 1;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

  typedef struct packed {
    ctx_t ctx;
    logic dzero;
  } tag_t;

  function automatic logic signed [NUMER_WIDTH-1:0] join_pp(
    input logic signed [PP_HI_WIDTH-1:0] hi,
    input logic signed [PP_LO_WIDTH-1:0] lo
  );
    logic signed [NUMER_WIDTH-1:0] he, le;
    he = NUMER_WIDTH'(hi);
    le = NUMER_WIDTH'(lo);
    return (he <<< SPLIT_LO) + le;
  endfunction

  // Doubled numerator plus the divisor, with the sign of the divisor moved onto the numerator.
  function automatic logic signed [MAG_WIDTH-1:0] make_m(
    input logic signed [NUMER_WIDTH-1:0] n,
    input logic [CROSS_WIDTH-1:0]        dabs,
    input logic                          neg
  );
    logic signed [MAG_WIDTH-1:0] n2, de;
    n2 = MAG_WIDTH'(n) <<< 1;
    de = signed'(MAG_WIDTH'(dabs));
    return neg ? de - n2 : de + n2;
  endfunction

  // A negative dividend is folded so that the division floors toward minus infinity.
  function automatic logic [MAG_WIDTH-1:0] make_mag(
    input logic signed [MAG_WIDTH-1:0] m,
    input logic [DIVISOR_WIDTH-1:0]    dd
  );
    logic [MAG_WIDTH-1:0] de;
    de = MAG_WIDTH'(dd);
    return m[MAG_WIDTH-1] ? de + ~m : m;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic [QUOT_WIDTH-1:0]         q,
    input logic                          neg,
    input logic                          ovf,
    input logic                          dzero
  );
    logic signed [SUM_WIDTH-1:0] ae, qe, sum;
    logic                        fits;
    ae   = SUM_WIDTH'(a);
    qe   = signed'(SUM_WIDTH'(q));
    sum  = neg ? ae - qe : ae + qe;
    fits = (&sum[SUM_WIDTH-1:COORD_WIDTH-1]) || !(|sum[SUM_WIDTH-1:COORD_WIDTH-1]);
    if (dzero) begin
      return '0;
    end else if (ovf) begin
      return neg ? COORD_MIN : COORD_MAX;
    end else if (fits) begin
      return sum[COORD_WIDTH-1:0];
    end else begin
      return sum[SUM_WIDTH-1] ? COORD_MIN : COORD_MAX;
    end
  endfunction

  logic              adv;
  logic [NSTAGE-1:0] vld;

  logic signed [SPLIT_LO:0]         num_lo;
  logic signed [SPLIT_HI-1:0]       num_hi;
  logic signed [PP_LO_WIDTH-1:0]    ppxl0, ppyl0;
  logic signed [PP_HI_WIDTH-1:0]    ppxh0, ppyh0;
  logic [CROSS_WIDTH-1:0]           dabs0, dabs1;
  logic                             dneg0, dneg1;
  tag_t                             tag0, tag1, tag2, tag3, tag_s;
  logic signed [NUMER_WIDTH-1:0]    nx1, ny1;
  logic signed [MAG_WIDTH-1:0]      mx2, my2;
  logic [DIVISOR_WIDTH-1:0]         dd2, dd3;
  logic [MAG_WIDTH-1:0]             magx3, magy3;
  logic                             negx3, negy3;
  tag_t                             tagd [DIV_LAT];
  logic [QUOT_WIDTH-1:0]            qx, qy;
  logic                             ovfx, ovfy, negx, negy;

  logic signed [COORD_WIDTH-1:0]    px_s, py_s, px1, py1, px2, py2, px3, py3;
  logic signed [COORD_WIDTH-1:0]    p_sel, c_sel;
  logic signed [DIFF_WIDTH-1:0]     s_sel;
  logic signed [DIFF_WIDTH-1:0]     u1, u2, ex1, ey1, rx1, ry1;
  logic [DIFF_WIDTH-1:0]            dab1, dab2;
  logic                             segz1, segz2;
  logic [TOL_WIDTH+DIFF_WIDTH-1:0]  tpd2;
  logic signed [2*DIFF_WIDTH-1:0]   dotx2, doty2;
  logic signed [PT_WIDTH-1:0]       ue, de, tpde, low_sum, high_sum;
  logic                             posok3;
  logic signed [DOT_WIDTH-1:0]      dot3;
  logic signed [DT_WIDTH-1:0]       dot_sh, lim, dot_sum;

  // One enable for the whole back pipeline; it holds while the output word is stalled.
  assign adv = !(result_valid && result_stall);
  assign pop = adv && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[NSTAGE-2:0], avail};
      result_valid <= vld[NSTAGE-1];
    end
  end

  // Ray direction times numerator, split in two partial products per axis.
  assign num_lo = signed'({1'b0, head.num[SPLIT_LO-1:0]});
  assign num_hi = head.num[CROSS_WIDTH-1:SPLIT_LO];

  always_ff @(posedge clk) begin
    if (adv) begin
      ppxl0      <= head.ctx.rx * num_lo;
      ppxh0      <= head.ctx.rx * num_hi;
      ppyl0      <= head.ctx.ry * num_lo;
      ppyh0      <= head.ctx.ry * num_hi;
      dabs0      <= head.den[CROSS_WIDTH-1] ? -head.den : head.den;
      dneg0      <= head.den[CROSS_WIDTH-1];
      tag0.ctx   <= head.ctx;
      tag0.dzero <= head.den == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx1   <= join_pp(ppxh0, ppxl0);
      ny1   <= join_pp(ppyh0, ppyl0);
      dabs1 <= dabs0;
      dneg1 <= dneg0;
      tag1  <= tag0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx2  <= make_m(nx1, dabs1, dneg1);
      my2  <= make_m(ny1, dabs1, dneg1);
      dd2  <= {dabs1, 1'b0};
      tag2 <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      magx3 <= make_mag(mx2, dd2);
      magy3 <= make_mag(my2, dd2);
      negx3 <= mx2[MAG_WIDTH-1];
      negy3 <= my2[MAG_WIDTH-1];
      dd3   <= dd2;
      tag3  <= tag2;
    end
  end

  rsi_divider u_div_x (
    .clk     (clk),
    .en      (adv),
    .mag     (magx3),
    .dd      (dd3),
    .neg     (negx3),
    .quot    (qx),
    .ovf     (ovfx),
    .neg_out (negx)
  );

  rsi_divider u_div_y (
    .clk     (clk),
    .en      (adv),
    .mag     (magy3),
    .dd      (dd3),
    .neg     (negy3),
    .quot    (qy),
    .ovf     (ovfy),
    .neg_out (negy)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      tagd[0] <= tag3;
      for (int i = 1; i < DIV_LAT; i++) begin
        tagd[i] <= tagd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_s  <= sat_coord(tagd[DIV_LAT-1].ctx.ax, qx, negx, ovfx, tagd[DIV_LAT-1].dzero);
      py_s  <= sat_coord(tagd[DIV_LAT-1].ctx.ay, qy, negy, ovfy, tagd[DIV_LAT-1].dzero);
      tag_s <= tagd[DIV_LAT-1];
    end
  end

  assign p_sel = tag_s.ctx.sel_x ? px_s : py_s;
  assign c_sel = tag_s.ctx.sel_x ? tag_s.ctx.cx : tag_s.ctx.cy;
  assign s_sel = tag_s.ctx.sel_x ? tag_s.ctx.sx : tag_s.ctx.sy;

  always_ff @(posedge clk) begin
    if (adv) begin
      u1    <= s_sel[DIFF_WIDTH-1] ? DIFF_WIDTH'(c_sel) - DIFF_WIDTH'(p_sel)
                                   : DIFF_WIDTH'(p_sel) - DIFF_WIDTH'(c_sel);
      dab1  <= s_sel[DIFF_WIDTH-1] ? -s_sel : s_sel;
      ex1   <= DIFF_WIDTH'(px_s) - DIFF_WIDTH'(tag_s.ctx.ax);
      ey1   <= DIFF_WIDTH'(py_s) - DIFF_WIDTH'(tag_s.ctx.ay);
      rx1   <= tag_s.ctx.rx;
      ry1   <= tag_s.ctx.ry;
      segz1 <= tag_s.ctx.seg_zero;
      px1   <= px_s;
      py1   <= py_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u2    <= u1;
      dab2  <= dab1;
      tpd2  <= pos_tol * dab1;
      dotx2 <= rx1 * ex1;
      doty2 <= ry1 * ey1;
      segz2 <= segz1;
      px2   <= px1;
      py2   <= py1;
    end
  end

  // Position bounds in units of 2^-16 of the segment extent, widened by the tolerance.
  assign ue       = PT_WIDTH'(u2) <<< TOL_WIDTH;
  assign de       = signed'(PT_WIDTH'(dab2)) <<< TOL_WIDTH;
  assign tpde     = signed'(PT_WIDTH'(tpd2));
  assign low_sum  = ue + tpde;
  assign high_sum = ue - de - tpde;

  always_ff @(posedge clk) begin
    if (adv) begin
      posok3 <= !segz2 && !low_sum[PT_WIDTH-1]
                && (high_sum[PT_WIDTH-1] || high_sum == '0);
      dot3   <= DOT_WIDTH'(dotx2) + DOT_WIDTH'(doty2);
      px3    <= px2;
      py3    <= py2;
    end
  end

  assign dot_sh  = DT_WIDTH'(dot3) <<< TOL_WIDTH;
  assign lim     = signed'(DT_WIDTH'(dir_tol) << (2 * FRAC_BITS));
  assign dot_sum = dot_sh + lim;

  always_ff @(posedge clk) begin
    if (adv) begin
      result.hit     <= posok3 && !dot_sum[DT_WIDTH-1];
      result.cross_x <= px3;
      result.cross_y <= py3;
    end
  end

endmodule

// ===== dv/tb_ray_segment_intersection_core.sv =====
// Self-checking testbench for the ray and segment intersection core.
`timescale 1ns / 1ps

module tb_ray_segment_intersection_core;
  import rsi_pkg::*;

  // Pipeline depth from acceptance to result, plus some slack for the back end.
  localparam int PIPE_LATENCY = 13 + COORD_WIDTH + 1;
  localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
  // Cycles without any word moved before the run is declared hung.
  localparam int HANG_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 4;
  localparam int FRAC         = COORD_FRAC_BITS_DEF;

  typedef logic signed [127:0] wide_t;

  localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [TOL_WIDTH-1:0] cfg_data = '0;

  ray_segment_intersection_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copies of the two tolerance registers, updated when a write lands.
  logic [TOL_WIDTH-1:0] pos_tol_shadow = '0;
  logic [TOL_WIDTH-1:0] dir_tol_shadow = '0;

  item_t   pending_words[$];
  result_t expected_hits[$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  bit      word_taken = 1'b0;

  // Round n/d to nearest with ties toward plus infinity.
  function automatic wide_t round_quotient(wide_t n, wide_t d);
    wide_t m, dd, q;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    m = 2 * n + d;
    dd = 2 * d;
    q = m / dd;
    if (m < 0 && q * dd != m) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_coord(wide_t v);
    if (v < wide_t'(COORD_MIN)) return COORD_MIN;
    if (v > wide_t'(COORD_MAX)) return COORD_MAX;
    return longint'(v);
  endfunction

  // Line crossing by Cramer's rule, then the segment position and ray direction tests.
  function automatic result_t intersect_ray(item_t w);
    longint ax, ay, bx, by, cx, cy, dx, dy, rx, ry, sx, sy;
    longint px, py, u, d, adx, ady, tp;
    wide_t den, num, dot, lim;
    logic hit;
    result_t r;
    ax = w.ray_origin_x; ay = w.ray_origin_y;
    bx = w.ray_target_x; by = w.ray_target_y;
    cx = w.seg_start_x;  cy = w.seg_start_y;
    dx = w.seg_end_x;    dy = w.seg_end_y;
    rx = bx - ax; ry = by - ay; sx = dx - cx; sy = dy - cy;
    px = 0; py = 0; hit = 1'b1;
    den = wide_t'(rx * sy - ry * sx);
    // Parallel lines and a zero-length ray leave the point at the origin.
    if (den != 0) begin
      num = wide_t'((cx - ax) * sy - (cy - ay) * sx);
      px = clamp_coord(wide_t'(ax) + round_quotient(wide_t'(rx) * num, den));
      py = clamp_coord(wide_t'(ay) + round_quotient(wide_t'(ry) * num, den));
    end
    adx = sx < 0 ? -sx : sx;
    ady = sy < 0 ? -sy : sy;
    u = 0; d = 0;
    if (adx > ady) begin
      u = px - cx; d = sx;
    end else if (sy != 0) begin
      u = py - cy; d = sy;
    end else begin
      hit = 1'b0;
    end
    if (hit) begin
      tp = pos_tol_shadow;
      if (d < 0) begin
        u = -u; d = -d;
      end
      if (u * 65536 < -tp * d || u * 65536 > (65536 + tp) * d) hit = 1'b0;
    end
    if (hit) begin
      dot = (wide_t'(rx) * wide_t'(px - ax) + wide_t'(ry) * wide_t'(py - ay)) <<< 16;
      lim = wide_t'(dir_tol_shadow) <<< (2 * FRAC);
      if (dot + lim < 0) hit = 1'b0;
    end
    r.hit = hit;
    r.cross_x = px[COORD_WIDTH-1:0];
    r.cross_y = py[COORD_WIDTH-1:0];
    return r;
  endfunction

  function automatic longint rand_coord(int span_bits);
    longint v;
    v = longint'($urandom_range((1 << span_bits) - 1, 0)) - (64'sd1 <<< (span_bits - 1));
    return v;
  endfunction

  function automatic item_t make_word(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy, longint dx, longint dy);
    item_t w;
    w.ray_origin_x = ax[COORD_WIDTH-1:0]; w.ray_origin_y = ay[COORD_WIDTH-1:0];
    w.ray_target_x = bx[COORD_WIDTH-1:0]; w.ray_target_y = by[COORD_WIDTH-1:0];
    w.seg_start_x  = cx[COORD_WIDTH-1:0]; w.seg_start_y  = cy[COORD_WIDTH-1:0];
    w.seg_end_x    = dx[COORD_WIDTH-1:0]; w.seg_end_y    = dy[COORD_WIDTH-1:0];
    return w;
  endfunction

  // A ray aimed at a point near or on the segment, mostly from in front, sometimes behind.
  function automatic item_t aimed_word();
    int k, t;
    longint ax, ay, cx, cy, dx, dy, qx, qy;
    k = $urandom_range(COORD_WIDTH - 3, 4);
    cx = rand_coord(k); cy = rand_coord(k);
    dx = rand_coord(k); dy = rand_coord(k);
    ax = rand_coord(k); ay = rand_coord(k);
    case ($urandom_range(3))
      0: t = 0;
      1: t = 1024;
      default: t = $urandom_range(1100, 0) - 40;
    endcase
    qx = cx + ((dx - cx) * t) / 1024;
    qy = cy + ((dy - cy) * t) / 1024;
    if ($urandom_range(4) == 0) begin
      // Point behind the origin.
      qx = 2 * ax - qx;
      qy = 2 * ay - qy;
    end
    return make_word(ax, ay, qx, qy, cx, cy, dx, dy);
  endfunction

  function automatic item_t noise_word();
    item_t w;
    w = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [TOL_WIDTH-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || item_valid || expected_hits.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: a new word goes out once the previous one was taken, with random gaps.
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_valid || word_taken) begin
        word_taken = 1'b0;
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          item <= pending_words.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on every accepted word and checks every accepted result.
  always @(posedge clk) begin
    result_t exp_r;
    bit      moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index == REG_POSITION_TOL) pos_tol_shadow <= cfg_data;
        else if (cfg_index == REG_DIRECTION_TOL) dir_tol_shadow <= cfg_data;
      end
      if (item_valid && !item_stall) begin
        moved = 1'b1;
        word_taken = 1'b1;
        expected_hits.push_back(intersect_ray(item));
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        if (expected_hits.size() == 0) begin
          $error("result word with nothing expected: %h", result);
          mismatches++;
        end else begin
          exp_r = expected_hits.pop_front();
          if (result.hit !== exp_r.hit) begin
            $error("hit: expected %0b, got %0b", exp_r.hit, result.hit);
            mismatches++;
          end
          if (result.cross_x !== exp_r.cross_x) begin
            $error("cross_x: expected %0d, got %0d", exp_r.cross_x, result.cross_x);
            mismatches++;
          end
          if (result.cross_y !== exp_r.cross_y) begin
            $error("cross_y: expected %0d, got %0d", exp_r.cross_y, result.cross_y);
            mismatches++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("FAIL ray_segment_intersection_core");
        $finish;
      end
    end
  end

  initial begin
    longint big;
    int p;
    big = COORD_MAX;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words run with the reset tolerances of zero.
    pending_words.push_back(make_word(0, 0, 256, 0, 512, -256, 512, 256));      // plain hit
    pending_words.push_back(make_word(0, 0, -256, 0, 512, -256, 512, 256));     // behind ray
    pending_words.push_back(make_word(0, 0, 256, 0, 0, 256, 512, 256));         // parallel
    pending_words.push_back(make_word(0, 0, 256, 256, 0, 0, 512, 512));         // collinear
    pending_words.push_back(make_word(5, 5, 5, 5, 0, -256, 0, 256));            // zero ray
    pending_words.push_back(make_word(0, 0, 256, 0, 300, 300, 300, 300));       // point segment
    pending_words.push_back(make_word(0, 0, 256, 0, 512, 0, 512, 256));         // at seg start
    pending_words.push_back(make_word(0, 0, 256, 0, 512, -256, 512, 0));        // at seg end
    pending_words.push_back(make_word(0, 0, 256, 0, 512, 1, 512, 256));         // just outside
    pending_words.push_back(make_word(0, 0, 256, 0, 512, 100, 612, -100));      // y axis longer
    pending_words.push_back(make_word(0, 0, 256, 0, 512, -256, 1536, 256));     // x axis longer
    pending_words.push_back(make_word(0, 0, 256, 256, 256, 256, 512, 0));       // hit at seg start
    pending_words.push_back(make_word(COORD_MIN, COORD_MIN, big, big,
                                      COORD_MIN, big, big, COORD_MIN));          // extremes
    pending_words.push_back(make_word(big, COORD_MIN, COORD_MIN, big,
                                      big, big, COORD_MIN, COORD_MIN));
    pending_words.push_back(make_word(0, 0, 1 << 22, 1, -(1 << 22), 10,
                                      1 << 22, 11));                             // saturates
    pending_words.push_back(make_word(0, 0, -(1 << 22), 1, -(1 << 22), -10,
                                      1 << 22, -11));
    pending_words.push_back(make_word(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_words.push_back(make_word(1, 0, 0, 1, big, 0, 0, big));
    wait_idle();

    // Each phase changes the tolerances, then sends random words under one idle pattern.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_POSITION_TOL, '0);
          write_reg(REG_DIRECTION_TOL, '0);
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          write_reg(REG_POSITION_TOL, '1);
          write_reg(REG_DIRECTION_TOL, '1);
          idle_pct = 54; stall_pct = 0;
        end
        2: begin
          write_reg(REG_POSITION_TOL, TOL_WIDTH'($urandom_range(2000)));
          write_reg(REG_DIRECTION_TOL, TOL_WIDTH'($urandom));
          // Index beyond the two registers must be ignored.
          write_reg(CFG_INDEX_WIDTH'(3), '1);
          idle_pct = 0; stall_pct = 54;
        end
        default: begin
          write_reg(REG_POSITION_TOL, TOL_WIDTH'($urandom));
          write_reg(REG_DIRECTION_TOL, TOL_WIDTH'($urandom_range(50)));
          idle_pct = 29; stall_pct = 29;
        end
      endcase
      repeat (RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(99) < 75) pending_words.push_back(aimed_word());
        else pending_words.push_back(noise_word());
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("PASS ray_segment_intersection_core");
    end else begin
      $display("FAIL ray_segment_intersection_core");
    end
    $finish;
  end

endmodule

// ===== ray_segment_intersection_core.f =====
rtl/core/rsi_pkg.sv
rtl/core/rsi_front.sv
rtl/core/rsi_queue.sv
rtl/core/rsi_divider.sv
rtl/core/rsi_back.sv
rtl/core/ray_segment_intersection_core.sv
dv/tb_ray_segment_intersection_core.sv
